// ===== sv/ptp_pkg.sv =====
// Package for the perspective point transform: widths, defaults and shared types.
// No dependencies; compiled first.
package ptp_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ProdW       = 64;
  localparam int unsigned SumW        = 68;

  typedef enum logic {
    CMD_POINT  = 1'b0,
    CMD_VECTOR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               was_divided;
    logic               saturated;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v,
                                               output logic hit);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(64'sh7FFFFFFF);
    lo = -SumW'(64'sh80000000);
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      hit = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== sv/ptp_if.sv =====
// Valid/ready stream interface carrying one payload of type T.
// Does not depend on ptp_pkg; the payload type is given by the parameter T.
interface ptp_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ptp_div.sv =====
// Pipelined restoring divider: signed 64-bit numerator by signed 32-bit divisor,
// one quotient bit per stage, truncating toward zero. Depends on ptp_pkg.
module ptp_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32,
  parameter int unsigned TagW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic signed [NumW:0]   quo_o,
  output logic [TagW-1:0]        tag_o
);
  import ptp_pkg::*;

  logic [NumW:0]   rem_q [NumW+1];
  logic [NumW-1:0] quo_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];
  logic            neg_q [NumW+1];
  logic            vld_q [NumW+1];
  logic [TagW-1:0] tag_q [NumW+1];

  logic [NumW-1:0] num_abs;
  logic [DenW-1:0] den_abs;
  assign num_abs = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign den_abs = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumW; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= NumW; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= num_abs;
      den_q[0] <= den_abs;
      neg_q[0] <= num_i[NumW-1] ^ den_i[DenW-1];
      tag_q[0] <= tag_i;
      for (int i = 1; i <= NumW; i++) begin
        logic [NumW:0] sh;
        logic [NumW:0] df;
        sh = {rem_q[i-1][NumW-1:0], quo_q[i-1][NumW-1]};
        df = sh - (NumW+1)'(den_q[i-1]);
        if (!df[NumW]) begin
          rem_q[i] <= df;
          quo_q[i] <= {quo_q[i-1][NumW-2:0], 1'b1};
        end else begin
          rem_q[i] <= sh;
          quo_q[i] <= {quo_q[i-1][NumW-2:0], 1'b0};
        end
        den_q[i] <= den_q[i-1];
        neg_q[i] <= neg_q[i-1];
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign tag_o   = tag_q[NumW];
  assign quo_o   = neg_q[NumW] ? -$signed({1'b0, quo_q[NumW]})
                               : $signed({1'b0, quo_q[NumW]});
endmodule

// ===== sv/ptp_mac.sv =====
// Matrix stage: four saturated row sums over three registered stages (products, sums, saturation).
// Depends on ptp_pkg.
module ptp_mac #(
  parameter int unsigned FracBits = ptp_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  ptp_pkg::in_item_t            item_i,
  input  logic [ptp_pkg::CfgDataW-1:0] mat_i [ptp_pkg::NumRegs],
  output logic                         valid_o,
  output logic                         vec_o,
  output logic signed [31:0]           r_o [4],
  output logic [3:0]                   sat_o
);
  import ptp_pkg::*;

  logic signed [ProdW-1:0] prod_q [4][3];
  logic signed [31:0]      tr_q   [4];
  logic                    v1_q, v2_q, vec1_q, vec2_q;
  logic signed [SumW-1:0]  hi_q [4];
  logic [FracBits+1:0]     lo_q [4];
  logic signed [31:0]      r_q [4];
  logic [3:0]              s_q;
  logic                    v3_q, vec3_q;

  function automatic logic signed [31:0] ent(input int c, input int r,
                                             input logic [CfgDataW-1:0] m [NumRegs]);
    logic [CfgDataW-1:0] w;
    w = m[c*2 + r/2];
    return (r % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec1_q <= item_i.cmd;
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= ProdW'(ent(0, r, mat_i)) * ProdW'(item_i.in_x);
        prod_q[r][1] <= ProdW'(ent(1, r, mat_i)) * ProdW'(item_i.in_y);
        prod_q[r][2] <= ProdW'(ent(2, r, mat_i)) * ProdW'(item_i.in_z);
        tr_q[r] <= (item_i.cmd == CMD_VECTOR) ? 32'sd0 : ent(3, r, mat_i);
      end
      vec2_q <= vec1_q;
      for (int r = 0; r < 4; r++) begin
        hi_q[r] <= SumW'(prod_q[r][0] >>> FracBits) + SumW'(prod_q[r][1] >>> FracBits)
                 + SumW'(prod_q[r][2] >>> FracBits) + SumW'(tr_q[r]);
        lo_q[r] <= (FracBits+2)'(prod_q[r][0][FracBits-1:0])
                 + (FracBits+2)'(prod_q[r][1][FracBits-1:0])
                 + (FracBits+2)'(prod_q[r][2][FracBits-1:0]);
      end
      vec3_q <= vec2_q;
      for (int r = 0; r < 4; r++) begin
        logic h;
        r_q[r] <= sat32(hi_q[r] + SumW'(lo_q[r][FracBits+1:FracBits]), h);
        s_q[r] <= h;
      end
    end
  end

  assign valid_o = v3_q;
  assign vec_o   = vec3_q;
  assign r_o     = r_q;
  assign sat_o   = s_q;
endmodule

// ===== sv/point_transform_perspective.sv =====
// Perspective point transform: 4x4 matrix times a Q16.16 point, then divide points by w unless w is 0 or 1.0.
// One transfer per cycle sustained while out_if is not stalled; the pipeline is 3 matrix
// stages, 1 select stage, 65 divider stages and 1 output stage.
module point_transform_perspective #(
  parameter int unsigned FRAC_BITS = ptp_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ptp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptp_pkg::CfgDataW-1:0] cfg_data_i,
  ptp_if.sink                          in_if,
  ptp_if.source                        out_if
);
  import ptp_pkg::*;

  localparam logic [31:0] One = 32'(1) << FRAC_BITS;

  logic [CfgDataW-1:0] mat_q [NumRegs];
  logic en, mv, vec, sel_v_q, sel_vec_q, sel_div_q, sel_sat_q;
  logic signed [31:0] r [4];
  logic [3:0] rs;
  logic signed [31:0] sel_r_q [3];
  logic signed [31:0] sel_w_q;
  logic dv [3];
  logic signed [64:0] dq [3];
  logic [2:0] dtag [3];
  logic       dtagu;
  logic       ov_q;
  out_item_t  o_q;

  assign en = !ov_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) mat_q[i] <= '0;
      mat_q[0] <= CfgDataW'(One);
      mat_q[2] <= {One, 32'd0};
      mat_q[5] <= CfgDataW'(One);
      mat_q[7] <= {One, 32'd0};
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  ptp_mac #(.FracBits(FRAC_BITS)) u_mac (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid), .item_i(in_if.data),
    .mat_i(mat_q), .valid_o(mv), .vec_o(vec), .r_o(r), .sat_o(rs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_v_q <= 1'b0;
    else if (en) sel_v_q <= mv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic d;
      d = !vec && r[3] != 32'sd0 && r[3] != $signed(One);
      sel_div_q <= d;
      sel_vec_q <= vec;
      sel_sat_q <= rs[0] | rs[1] | rs[2] | (d & rs[3]);
      sel_w_q   <= d ? r[3] : 32'sd1;
      for (int i = 0; i < 3; i++) sel_r_q[i] <= r[i];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    ptp_div #(.NumW(64), .DenW(32), .TagW(3)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sel_v_q),
      .num_i(sel_div_q ? 64'(sel_r_q[g]) <<< FRAC_BITS : 64'(sel_r_q[g])),
      .den_i(sel_w_q), .tag_i({sel_v_q, sel_div_q, sel_sat_q}),
      .valid_o(dv[g]), .quo_o(dq[g]), .tag_o(dtag[g])
    );
  end

  assign dtagu = dtag[1][2] & dtag[2][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= dv[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic h0, h1, h2;
      o_q.out_x <= sat32(SumW'(dq[0]), h0);
      o_q.out_y <= sat32(SumW'(dq[1]), h1);
      o_q.out_z <= sat32(SumW'(dq[2]), h2);
      o_q.was_divided <= dtag[0][1];
      o_q.saturated <= dtag[0][0] | h0 | h1 | h2;
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = o_q;

  a_div_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[0] |-> (dv[1] && dv[2] && dtagu)) else $error("divider lanes out of step");
  a_vec_nodiv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_v_q && sel_vec_q) |-> !sel_div_q) else $error("vector item divided");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> (ov_q && $stable(o_q))) else $error("result lost");
endmodule
